[rtl/tel_pkg.sv]
// Package for the timestamp event log: sizes, request/record types, controller states.
`timescale 1ns / 1ps

package tel_pkg;

  // Slots in the circular store; at most LOG_DEPTH-1 entries are kept
  localparam int unsigned LOG_DEPTH = 16;
  localparam int unsigned PTR_W     = $clog2(LOG_DEPTH);
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned ID_W      = 64;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned ENTRY_W   = ID_W + TIME_W;

  // Request type codes
  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_FETCH   = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] event_time;
    logic [CNT_W-1:0]  max_records;
  } tel_req_t;

  typedef struct packed {
    logic              record_valid;
    logic [ID_W-1:0]   record_id;
    logic [TIME_W-1:0] record_time;
    logic [CNT_W-1:0]  record_index;
    logic              last_record;
  } tel_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_EMIT,
    ST_HOLD
  } tel_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic start_fetch;
    logic load_rec;
    logic load_empty;
  } tel_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic has_data;
    logic out_last;
  } tel_sts_t;

endpackage

[rtl/timestamp_event_log.sv]
// Top level of the timestamp event log.
`timescale 1ns / 1ps

// Timestamped event log over a circular store of LOG_DEPTH slots.
// Input channel (in_valid_i/in_ready_o/in_data_i): a capture request stores
// event_time with a running 64-bit sequence number; a fetch request drains
// up to max_records oldest entries. When the store is full the oldest entry
// is dropped, so at most LOG_DEPTH-1 entries are kept.
// Output channel (out_valid_o/out_ready_i/out_data_o): one record per drained
// entry, last_record on the final one; an empty fetch gives a single record
// with record_valid low.
// Throughput: captures are taken back to back while idle. A fetch is accepted,
// then each record passes the FETCH (address), LOAD (store read) and EMIT
// (output register) states, set by the registered read of the store; an
// empty fetch loads its record in FETCH and shows it in EMIT.
// A new request is taken while the final record of a fetch still waits.
// A stalled receiver holds the output register and the fetch pauses.
// Reset clears the pointers and sequence number; the log starts empty.
module timestamp_event_log (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tel_pkg::tel_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tel_pkg::tel_rec_t out_data_o
);

  tel_pkg::tel_cmd_t cmd;
  tel_pkg::tel_sts_t sts;

  tel_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_data_i.req_type),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tel_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

[rtl/tel_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tel_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/tel_datapath.sv]
// Datapath of the event log: pointers, sequence counter, store and output register.
`timescale 1ns / 1ps

module tel_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tel_pkg::tel_req_t in_data_i,
  input  tel_pkg::tel_cmd_t cmd_i,
  output tel_pkg::tel_sts_t sts_o,
  output tel_pkg::tel_rec_t out_data_o
);

  localparam logic [tel_pkg::PTR_W-1:0] LAST_SLOT = tel_pkg::PTR_W'(tel_pkg::LOG_DEPTH - 1);

  logic [tel_pkg::PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [tel_pkg::PTR_W-1:0]   wr_inc, rd_inc;
  logic [tel_pkg::ID_W-1:0]    seq_q, seq_d;
  logic [tel_pkg::CNT_W-1:0]   cnt_q, cnt_d, limit_q, limit_d;
  logic [tel_pkg::ENTRY_W-1:0] rdata;
  logic                        cnt_hits_limit;
  tel_pkg::tel_rec_t           out_q, out_d;

  // Store of {id, time} entries
  tel_ram #(
    .WIDTH (tel_pkg::ENTRY_W),
    .DEPTH (tel_pkg::LOG_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.capture),
    .waddr_i (wr_q),
    .wdata_i ({seq_q, in_data_i.event_time}),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  // Wrapping slot increments
  assign wr_inc = (wr_q == LAST_SLOT) ? '0 : wr_q + 1'b1;
  assign rd_inc = (rd_q == LAST_SLOT) ? '0 : rd_q + 1'b1;

  assign cnt_hits_limit = ({1'b0, cnt_q} + 9'd1) == {1'b0, limit_q};

  // Next pointer, count and record values
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    seq_d = seq_q;
    cnt_d = cnt_q;
    limit_d = limit_q;
    out_d = out_q;
    if (cmd_i.capture) begin
      wr_d  = wr_inc;
      seq_d = seq_q + 1'b1;
      // drop the oldest entry when the writer catches the reader
      if (wr_inc == rd_q) begin
        rd_d = rd_inc;
      end
    end
    if (cmd_i.start_fetch) begin
      limit_d = in_data_i.max_records;
      cnt_d   = '0;
    end
    if (cmd_i.load_rec) begin
      out_d.record_valid = 1'b1;
      out_d.record_id    = rdata[tel_pkg::ENTRY_W-1:tel_pkg::TIME_W];
      out_d.record_time  = rdata[tel_pkg::TIME_W-1:0];
      out_d.record_index = cnt_q;
      out_d.last_record  = (rd_inc == wr_q) || cnt_hits_limit;
      rd_d  = rd_inc;
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.load_empty) begin
      out_d = '0;
      out_d.last_record = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      seq_q   <= '0;
      cnt_q   <= '0;
      limit_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      seq_q   <= seq_d;
      cnt_q   <= cnt_d;
      limit_q <= limit_d;
    end
  end

  // Output record register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign sts_o.has_data = (rd_q != wr_q) && (cnt_q < limit_q);
  assign sts_o.out_last = out_q.last_record;
  assign out_data_o     = out_q;

endmodule

[rtl/tel_ctrl.sv]
// Controller state machine of the event log.
`timescale 1ns / 1ps

module tel_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              req_type_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tel_pkg::tel_sts_t sts_i,
  output tel_pkg::tel_cmd_t cmd_o
);

  tel_pkg::tel_state_e state_q, state_d;
  logic                accept;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tel_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Take a request when idle or while the final record of a fetch waits
  assign in_ready_o = (state_q == tel_pkg::ST_IDLE) ||
                      ((state_q == tel_pkg::ST_EMIT) && sts_i.out_last);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d           = state_q;
    out_valid_o       = 1'b0;
    cmd_o             = '0;
    cmd_o.capture     = accept && (req_type_i == tel_pkg::REQ_CAPTURE);
    cmd_o.start_fetch = accept && (req_type_i == tel_pkg::REQ_FETCH);
    unique case (state_q)
      tel_pkg::ST_IDLE: begin
        if (cmd_o.start_fetch) begin
          state_d = tel_pkg::ST_FETCH;
        end
      end
      tel_pkg::ST_FETCH: begin
        // read address is presented now; empty fetch answers at once
        if (sts_i.has_data) begin
          state_d = tel_pkg::ST_LOAD;
        end else begin
          cmd_o.load_empty = 1'b1;
          state_d          = tel_pkg::ST_EMIT;
        end
      end
      tel_pkg::ST_LOAD: begin
        cmd_o.load_rec = 1'b1;
        state_d        = tel_pkg::ST_EMIT;
      end
      tel_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (!sts_i.out_last || cmd_o.start_fetch) begin
            state_d = tel_pkg::ST_FETCH;
          end else begin
            state_d = tel_pkg::ST_IDLE;
          end
        end else if (cmd_o.start_fetch) begin
          state_d = tel_pkg::ST_HOLD;
        end
      end
      tel_pkg::ST_HOLD: begin
        // hold the final record until taken, then start the queued fetch
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = tel_pkg::ST_FETCH;
        end
      end
      default: begin
        state_d = tel_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/tel_checker.sv]
// Port-level checker for the timestamp event log, with its bind.
`timescale 1ns / 1ps

module tel_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input tel_pkg::tel_req_t in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input tel_pkg::tel_rec_t out_data_o
);

  // Stalled record holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled record changed");

  // Requests are taken alongside a pending record only on the final one
  a_ready_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_ready_o |-> out_data_o.last_record)
    else $error("request taken mid-fetch");

  // Empty fetch record is final and at index zero
  a_empty_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.record_valid |->
      out_data_o.last_record && (out_data_o.record_index == '0))
    else $error("malformed empty record");

  // An accepted fetch blocks further requests next cycle
  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.req_type == tel_pkg::REQ_FETCH) |=> !in_ready_o)
    else $error("ready after fetch accept");

  // A non-final record taken keeps the fetch running
  a_fetch_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_record |=> !in_ready_o)
    else $error("fetch ended early");

endmodule

bind timestamp_event_log tel_checker u_tel_checker (.*);

[tb/sv/tb_timestamp_event_log.sv]
// Self-checking testbench for the timestamp event log: directed table, random traffic, predictor.
`timescale 1ns / 1ps

module tb_timestamp_event_log;
  import tel_pkg::*;

  localparam int unsigned CLK_PERIOD    = 20;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned DIRECTED_ROWS = 14;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam longint unsigned TIMEOUT_NS = 64'd400_000 * CLK_PERIOD;

  localparam tel_rec_t EMPTY_REC = '{1'b0, '0, '0, '0, 1'b1};

  // One directed request, with an optional typed-in record that overrides the prediction
  typedef struct packed {
    tel_req_t req;
    logic     pinned;
    tel_rec_t rec;
  } stim_row_t;

  typedef struct packed {
    logic     pinned;
    tel_rec_t rec;
  } row_pin_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PULSE
  } rx_mode_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  tel_req_t in_data_i   = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  tel_rec_t out_data_o;

  timestamp_event_log dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Log predictor state
  logic [ID_W-1:0]   log_ids   [LOG_DEPTH];
  logic [TIME_W-1:0] log_times [LOG_DEPTH];
  logic [PTR_W-1:0]  log_wr  = '0;
  logic [PTR_W-1:0]  log_rd  = '0;
  logic [ID_W-1:0]   log_seq = '0;

  tel_rec_t  expected_records [$];
  row_pin_t  row_pins [$];
  stim_row_t directed_rows [DIRECTED_ROWS];

  int unsigned error_count     = 0;
  int unsigned captures_seen   = 0;
  int unsigned fetches_seen    = 0;
  int unsigned records_checked = 0;
  int unsigned empty_fetches   = 0;
  int unsigned dropped_entries = 0;
  int unsigned burst_left      = 0;

  rx_mode_e    rx_mode  = RX_OPEN;
  int unsigned rx_phase = 0;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(LOG_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Apply one request to the log; queue the records it drains when emit is set
  task automatic log_model_step(input tel_req_t req, input bit emit);
    tel_rec_t    rec;
    int unsigned n;
    n = 0;
    if (req.req_type == REQ_CAPTURE) begin
      log_ids[log_wr]   = log_seq;
      log_times[log_wr] = req.event_time;
      log_seq           = log_seq + 1'b1;
      log_wr            = next_slot(log_wr);
      // Drop the oldest entry once the write side catches up
      if (log_wr == log_rd) begin
        log_rd = next_slot(log_rd);
        dropped_entries++;
      end
    end else begin
      while (log_rd != log_wr && n < req.max_records) begin
        rec.record_valid = 1'b1;
        rec.record_id    = log_ids[log_rd];
        rec.record_time  = log_times[log_rd];
        rec.record_index = CNT_W'(n);
        log_rd           = next_slot(log_rd);
        n++;
        rec.last_record  = (log_rd == log_wr) || (n == req.max_records);
        if (emit) expected_records.push_back(rec);
      end
      if (n == 0 && emit) expected_records.push_back(EMPTY_REC);
    end
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic logic [TIME_W-1:0] random_stamp();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Send one request: open a new burst with a random gap, then hold until accepted
  task automatic send_request(input tel_req_t req, input bit pinned, input tel_rec_t pin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    row_pins.push_back('{pinned, pin});
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stall the receiver in phases of random pattern
  always @(posedge clk_i) begin
    if (rx_phase == 0) begin
      rx_mode  <= rx_mode_e'($urandom_range(0, 3));
      rx_phase <= $urandom_range(8, 64);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= (rx_phase[1:0] != 2'd0);
    endcase
  end

  // Predict on each accepted request, then check each accepted record
  always @(posedge clk_i) begin
    row_pin_t pin;
    tel_rec_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      pin = row_pins.pop_front();
      log_model_step(in_data_i, !pin.pinned);
      if (pin.pinned) expected_records.push_back(pin.rec);
      if (in_data_i.req_type == REQ_CAPTURE) captures_seen++;
      else fetches_seen++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_records.size() == 0) begin
        report_mismatch($sformatf("unexpected record %h", out_data_o));
      end else begin
        want = expected_records.pop_front();
        records_checked++;
        if (!want.record_valid) empty_fetches++;
        check_field("record_valid", 64'(out_data_o.record_valid), 64'(want.record_valid));
        check_field("record_id", out_data_o.record_id, want.record_id);
        check_field("record_time", out_data_o.record_time, want.record_time);
        check_field("record_index", 64'(out_data_o.record_index), 64'(want.record_index));
        check_field("last_record", 64'(out_data_o.last_record), 64'(want.last_record));
      end
    end
  end

  initial begin
    tel_req_t    req;
    int unsigned random_sent;
    int unsigned run_len;
    random_sent = 0;

    directed_rows = '{
      // Fetch from an empty log, with and without a limit
      '{'{REQ_FETCH, 64'h0123_4567_89AB_CDEF, 8'd5}, 1'b1, EMPTY_REC},
      '{'{REQ_FETCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0}, 1'b1, EMPTY_REC},
      '{'{REQ_CAPTURE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF}, 1'b0, EMPTY_REC},
      // Zero limit keeps the stored entry
      '{'{REQ_FETCH, 64'h0, 8'd0}, 1'b1, EMPTY_REC},
      '{'{REQ_FETCH, 64'h0, 8'd1}, 1'b1,
        '{1'b1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 1'b1}},
      '{'{REQ_CAPTURE, 64'h0, 8'h00}, 1'b0, EMPTY_REC},
      '{'{REQ_CAPTURE, 64'h8000_0000_0000_0001, 8'h80}, 1'b0, EMPTY_REC},
      '{'{REQ_CAPTURE, 64'h5555_5555_5555_5555, 8'h55}, 1'b0, EMPTY_REC},
      '{'{REQ_CAPTURE, 64'hAAAA_AAAA_AAAA_AAAA, 8'hAA}, 1'b0, EMPTY_REC},
      // Partial drain, then an oversized limit takes the rest
      '{'{REQ_FETCH, 64'h5A5A_5A5A_5A5A_5A5A, 8'd2}, 1'b0, EMPTY_REC},
      '{'{REQ_FETCH, 64'hA5A5_A5A5_A5A5_A5A5, 8'hFF}, 1'b0, EMPTY_REC},
      '{'{REQ_FETCH, 64'hFFFF_0000_FFFF_0000, 8'hFF}, 1'b1, EMPTY_REC},
      '{'{REQ_CAPTURE, 64'h0123_4567_89AB_CDEF, 8'h01}, 1'b0, EMPTY_REC},
      '{'{REQ_FETCH, 64'h0000_FFFF_0000_FFFF, 8'h80}, 1'b0, EMPTY_REC}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].rec);

    // Random traffic: mostly capture runs closed by a fetch, some loose requests
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 70) begin
        run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 8);
        repeat (run_len) begin
          req.req_type    = REQ_CAPTURE;
          req.event_time  = random_stamp();
          req.max_records = CNT_W'($urandom_range(0, 255));
          send_request(req, 1'b0, EMPTY_REC);
          random_sent++;
        end
        req.req_type   = REQ_FETCH;
        req.event_time = random_stamp();
        case ($urandom_range(0, 4))
          0:       req.max_records = 8'd0;
          1:       req.max_records = CNT_W'($urandom_range(1, 4));
          2:       req.max_records = 8'hFF;
          3:       req.max_records = CNT_W'($urandom_range(1, LOG_DEPTH - 1));
          default: req.max_records = CNT_W'($urandom_range(0, 255));
        endcase
      end else begin
        req.req_type    = $urandom_range(0, 1) ? REQ_FETCH : REQ_CAPTURE;
        req.event_time  = random_stamp();
        req.max_records = CNT_W'($urandom_range(0, 255));
      end
      send_request(req, 1'b0, EMPTY_REC);
      random_sent++;
    end

    // Drain outstanding records, then watch for strays
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d captures and %0d fetches; %0d entries dropped on overflow.",
             captures_seen, fetches_seen, dropped_entries);
    $display("Checked %0d records, %0d of them empty fetches; %0d mismatches.",
             records_checked, empty_fetches, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d records still expected.", expected_records.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/tel_pkg.sv
rtl/tel_ram.sv
rtl/tel_datapath.sv
rtl/tel_ctrl.sv
rtl/timestamp_event_log.sv
rtl/tel_checker.sv
tb/sv/tb_timestamp_event_log.sv
